/* src/sdma_pkg.sv */
`timescale 1ns / 1ps

package sdma_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned InDataW = 96;
	localparam int unsigned OutDataW = 72;

	localparam logic [WordW-1:0] BaseReset = 32'hF000_0000;
	localparam logic [WordW-1:0] StepBytes = 32'h0000_0004;

	// Register offsets from the base address
	localparam logic [WordW-1:0] OffSource = 32'h0000_0000;
	localparam logic [WordW-1:0] OffTarget = 32'h0000_0004;
	localparam logic [WordW-1:0] OffCount = 32'h0000_0008;
	localparam logic [WordW-1:0] OffControl = 32'h0000_000C;

	// Control register values
	localparam logic [WordW-1:0] CtrlStart = 32'h0000_0001;
	localparam logic [WordW-1:0] CtrlClear = 32'h0000_0000;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_READ = 3'd1,
		PH_WRITE = 3'd2,
		PH_ADVANCE = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef struct packed {
		logic slave_write;
		logic [WordW-1:0] slave_address;
		logic [WordW-1:0] slave_data;
		logic [WordW-1:0] master_read_data;
	} item_t;

	typedef struct packed {
		logic master_write;
		logic [WordW-1:0] master_address;
		logic [WordW-1:0] master_write_data;
		logic interrupt_request;
	} result_t;

	// Handshake between the input register and the result register
	typedef struct packed {
		logic step_en;
	} flow_t;

endpackage

/* src/sdma_in_stage.sv */
`timescale 1ns / 1ps

module sdma_in_stage import sdma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tuser,
	input  logic [InDataW-1:0] s_tdata,
	input  logic advance,
	output flow_t flow,
	output item_t item
);

	logic valid_s1;
	item_t item_s1;

	// The register empties whenever the result side can take a beat.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.slave_write <= s_tuser;
			item_s1.slave_address <= s_tdata[31:0];
			item_s1.slave_data <= s_tdata[63:32];
			item_s1.master_read_data <= s_tdata[95:64];
		end
	end

	always_comb begin
		flow.step_en = valid_s1 && advance;
	end

	assign item = item_s1;

endmodule

/* src/sdma_engine.sv */
`timescale 1ns / 1ps

module sdma_engine import sdma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  item_t item,
	input  logic [WordW-1:0] base_address,
	output result_t result
);

	phase_t phase_q, phase_d;
	logic [WordW-1:0] src_q, src_d;
	logic [WordW-1:0] dst_q, dst_d;
	logic [WordW-1:0] left_q, left_d;
	logic [WordW-1:0] start_q, start_d;
	logic [WordW-1:0] capt_q, capt_d;
	logic drv_wr_q, drv_wr_d;
	logic [WordW-1:0] drv_addr_q, drv_addr_d;
	logic [WordW-1:0] drv_data_q, drv_data_d;
	logic irq_q, irq_d;

	logic [WordW-1:0] offset;
	logic busy_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			src_q <= '0;
			dst_q <= '0;
			left_q <= '0;
			start_q <= '0;
			capt_q <= '0;
			drv_wr_q <= 1'b0;
			drv_addr_q <= '0;
			drv_data_q <= '0;
			irq_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			src_q <= src_d;
			dst_q <= dst_d;
			left_q <= left_d;
			start_q <= start_d;
			capt_q <= capt_d;
			drv_wr_q <= drv_wr_d;
			drv_addr_q <= drv_addr_d;
			drv_data_q <= drv_data_d;
			irq_q <= irq_d;
		end
	end

	assign offset = item.slave_address - base_address;
	assign busy_ok = (start_q == CtrlStart) && (left_q != '0);

	always_comb begin
		phase_d = phase_q;
		src_d = src_q;
		dst_d = dst_q;
		left_d = left_q;
		start_d = start_q;
		capt_d = capt_q;
		drv_wr_d = drv_wr_q;
		drv_addr_d = drv_addr_q;
		drv_data_d = drv_data_q;
		irq_d = irq_q;
		case (phase_q)
			PH_IDLE: begin
				if (item.slave_write) begin
					if (offset == OffSource) begin
						src_d = item.slave_data;
					end else if (offset == OffTarget) begin
						dst_d = item.slave_data;
					end else if (offset == OffCount) begin
						left_d = item.slave_data;
					end else if (offset == OffControl) begin
						start_d = item.slave_data;
						if (item.slave_data == CtrlStart && left_q != '0) begin
							phase_d = PH_READ;
							drv_wr_d = 1'b0;
							drv_addr_d = src_q;
						end
					end
				end
			end
			PH_READ: begin
				if (busy_ok) begin
					capt_d = item.master_read_data;
					phase_d = PH_WRITE;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_WRITE: begin
				if (busy_ok) begin
					drv_wr_d = 1'b1;
					drv_addr_d = dst_q;
					drv_data_d = capt_q;
					src_d = src_q + StepBytes;
					phase_d = PH_ADVANCE;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_ADVANCE: begin
				if (busy_ok) begin
					left_d = left_q - 32'd1;
					dst_d = dst_q + StepBytes;
					drv_wr_d = 1'b0;
					drv_addr_d = src_q;
					phase_d = (left_q == 32'd1) ? PH_DONE : PH_READ;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_DONE: begin
				irq_d = 1'b1;
				drv_wr_d = 1'b0;
				if (item.slave_write && offset == OffControl && item.slave_data == CtrlClear) begin
					irq_d = 1'b0;
					capt_d = '0;
					src_d = '0;
					dst_d = '0;
					left_d = '0;
					start_d = '0;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		result.master_write = drv_wr_d;
		result.master_address = drv_addr_d;
		result.master_write_data = drv_data_d;
		result.interrupt_request = irq_d;
	end

endmodule

/* src/sdma_out_stage.sv */
`timescale 1ns / 1ps

module sdma_out_stage import sdma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  result_t result,
	output logic advance,
	output logic m_tvalid,
	input  logic m_tready,
	output logic m_tuser,
	output logic [OutDataW-1:0] m_tdata
);

	logic valid_q;
	result_t result_q;

	assign advance = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= step_en;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser = result_q.master_write;
	assign m_tdata = {7'b0, result_q.interrupt_request, result_q.master_write_data,
		result_q.master_address};

endmodule

/* src/simple_dma_controller_core.sv */
`timescale 1ns / 1ps

// Single-channel word DMA engine, advanced by one beat at a time.
// Each slave-side beat carries the slave bus sample of one bus cycle (write
// strobe in tuser, address, write data and the master read data in tdata).
// The engine steps its state machine once per beat and answers with exactly
// one master-side beat holding the master port drive and the interrupt line
// as they stand after that step.
// The base of the four control registers is set through cfg_we/cfg_wdata
// while no beat is in flight, a rule the user must keep as the block does
// not enforce it; the base resets to 0xF000_0000. A beat waits in the input
// register and is stepped as it moves into the result register, which
// offers it; one beat per cycle passes while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register fills; once both are full s_tready falls until m_tready returns.
// Reset clears the state machine, all transfer registers and both handshake
// stages; no beat is offered until new input arrives.

module simple_dma_controller_core import sdma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [WordW-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tuser,                 // slave_write
	input  logic [InDataW-1:0] s_tdata,   // slave_address, slave_data, master_read_data
	output logic m_tvalid,
	input  logic m_tready,
	output logic m_tuser,                 // master_write
	output logic [OutDataW-1:0] m_tdata   // master_address, master_write_data,
	                                      // interrupt_request, zero fill
);

	logic [WordW-1:0] base_q;
	logic advance;
	flow_t flow;
	item_t item;
	result_t result;

	// Base address; user must change it only while the engine is quiet; unenforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BaseReset;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	sdma_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.advance(advance),
		.flow(flow),
		.item(item)
	);

	// The engine steps exactly when a beat moves into the result register.
	sdma_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(flow.step_en),
		.item(item),
		.base_address(base_q),
		.result(result)
	);

	sdma_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(flow.step_en),
		.result(result),
		.advance(advance),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata)
	);

endmodule
